>>> rtl/sbvg_pkg.sv
// shared types, constants and the vertex order table of the sphere band vertex generator
package sbvg_pkg;

  localparam int PHASE_W = 32;
  localparam int CW      = 34;   // cordic x/y width, signed q2.30 plus headroom
  localparam int ZW      = 33;   // cordic angle accumulator width

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [10:0] SLICE_RST  = 11'd16;
  localparam logic [10:0] STACK_RST  = 11'd16;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  // request kinds
  localparam logic [1:0] KIND_BAD     = 2'd0;
  localparam logic [1:0] KIND_EQUATOR = 2'd1;
  localparam logic [1:0] KIND_LOOP    = 2'd2;

  // vertex kinds
  localparam logic [1:0] VK_NORMAL = 2'd0;
  localparam logic [1:0] VK_TOP    = 2'd1;
  localparam logic [1:0] VK_BOTTOM = 2'd2;
  localparam logic [1:0] VK_ZERO   = 2'd3;

  // latitude selectors
  localparam logic [1:0] B_U0_POS = 2'd0;
  localparam logic [1:0] B_U0_NEG = 2'd1;
  localparam logic [1:0] B_U1_POS = 2'd2;
  localparam logic [1:0] B_U1_NEG = 2'd3;

  typedef struct packed {
    logic       alpha_hi;   // 0 slice i, 1 slice i+1
    logic [1:0] beta_sel;
    logic [1:0] vkind;
  } vsel_t;

  function automatic vsel_t vert_sel(input logic [4:0] idx, input logic equator);
    vsel_t v;
    v = '{alpha_hi: 1'b0, beta_sel: B_U0_POS, vkind: VK_NORMAL};
    if (equator) begin
      case (idx)
        5'd0: v = '{1'b0, B_U0_NEG, VK_NORMAL};
        5'd1: v = '{1'b1, B_U0_NEG, VK_NORMAL};
        5'd2: v = '{1'b0, B_U0_POS, VK_NORMAL};
        5'd3: v = '{1'b0, B_U0_POS, VK_NORMAL};
        5'd4: v = '{1'b1, B_U0_NEG, VK_NORMAL};
        5'd5: v = '{1'b1, B_U0_POS, VK_NORMAL};
        default: v = '{1'b0, B_U0_POS, VK_ZERO};
      endcase
    end else begin
      case (idx)
        5'd0:  v = '{1'b0, B_U0_POS, VK_NORMAL};
        5'd1:  v = '{1'b1, B_U0_POS, VK_NORMAL};
        5'd2:  v = '{1'b0, B_U1_POS, VK_NORMAL};
        5'd3:  v = '{1'b0, B_U1_POS, VK_NORMAL};
        5'd4:  v = '{1'b1, B_U0_POS, VK_NORMAL};
        5'd5:  v = '{1'b1, B_U1_POS, VK_NORMAL};
        5'd6:  v = '{1'b1, B_U0_NEG, VK_NORMAL};
        5'd7:  v = '{1'b0, B_U0_NEG, VK_NORMAL};
        5'd8:  v = '{1'b1, B_U1_NEG, VK_NORMAL};
        5'd9:  v = '{1'b1, B_U1_NEG, VK_NORMAL};
        5'd10: v = '{1'b0, B_U0_NEG, VK_NORMAL};
        5'd11: v = '{1'b0, B_U1_NEG, VK_NORMAL};
        5'd12: v = '{1'b0, B_U1_POS, VK_NORMAL};
        5'd13: v = '{1'b1, B_U1_POS, VK_NORMAL};
        5'd14: v = '{1'b0, B_U0_POS, VK_TOP};
        5'd15: v = '{1'b0, B_U0_POS, VK_BOTTOM};
        5'd16: v = '{1'b1, B_U1_NEG, VK_NORMAL};
        5'd17: v = '{1'b0, B_U1_NEG, VK_NORMAL};
        default: v = '{1'b0, B_U0_POS, VK_ZERO};
      endcase
    end
    return v;
  endfunction

endpackage

>>> rtl/sphere_band_vertex_generator.sv
// sphere band vertex generator: phase divider, vertex sequencer, cordic and multiply pipeline
// throughput: one vertex per cycle while the output is not stalled; a request emits 1, 6, 12 or 18 vertices
// intake: one request at a time; the divider runs 16 radix-4 iterations, hands off to the job register and
// only then takes a new request; a busy job register holds the divider until its last vertex
// reset: clears all valid and control state and loads radius 256, 16 slices, 16 stacks
module sphere_band_vertex_generator #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // slice_index[9:0], band_index[18:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // x_coord[16:0], y_coord[33:17], z_coord[50:34], zero pad
  output logic        m_tlast,    // last_vertex
  output logic        m_tuser,    // bad_request
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N = CORDIC_STEPS;
  localparam int CW = sbvg_pkg::CW;
  localparam int ZW = sbvg_pkg::ZW;
  localparam logic [10:0] MAX_L = (MAX_DIVISIONS > 2047) ? 11'h7FF : MAX_DIVISIONS[10:0];

  // configuration
  logic [15:0] radius;
  logic [10:0] slice_count;
  logic [10:0] stack_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= sbvg_pkg::RADIUS_RST;
      slice_count <= sbvg_pkg::SLICE_RST;
      stack_count <= sbvg_pkg::STACK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbvg_pkg::REG_RADIUS: radius      <= cfg_data;
        sbvg_pkg::REG_SLICES: slice_count <= cfg_data[10:0];
        sbvg_pkg::REG_STACKS: stack_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic [10:0] lim_l, lim_s;
  assign lim_l = (slice_count > MAX_L) ? MAX_L : slice_count;
  assign lim_s = (stack_count > MAX_L) ? MAX_L : stack_count;

  // request decode
  logic [9:0]  in_slice;
  logic [8:0]  in_band;
  logic        odd, ok, cap;
  logic [10:0] u0, u1, a1_init;
  logic [9:0]  band_p1;
  logic [1:0]  kind_in;

  always_comb begin
    in_slice = s_tdata[9:0];
    in_band  = s_tdata[18:10];
    odd      = lim_s[0];
    band_p1  = {1'b0, in_band} + 10'd1;
    ok       = (lim_l != 11'd0) && (lim_s != 11'd0) && ({1'b0, in_slice} < lim_l);
    if (in_band == 9'd0) ok = ok && odd;
    else                 ok = ok && (band_p1 <= lim_s[10:1]);
    cap      = (band_p1 == lim_s[10:1]);
    u0       = {10'd0, odd} + {1'b0, in_band - 9'd1, 1'b0};
    u1       = u0 + 11'd2;
    a1_init  = ({1'b0, in_slice} + 11'd1 == lim_l) ? 11'd0 : {1'b0, in_slice} + 11'd1;
    if (!ok)                    kind_in = sbvg_pkg::KIND_BAD;
    else if (in_band == 9'd0)   kind_in = sbvg_pkg::KIND_EQUATOR;
    else                        kind_in = sbvg_pkg::KIND_LOOP;
  end

  // phase divider: four lanes, two quotient bits per cycle
  logic        div_busy, div_done;
  logic [3:0]  div_cnt;
  logic [12:0] div_rem [4];
  logic [12:0] div_den [4];
  logic [31:0] div_quo [4];
  logic [1:0]  div_kind;
  logic        div_cap;
  logic [12:0] rem_next [4];
  logic [1:0]  qbits [4];

  function automatic logic [13:0] div_step(input logic [12:0] rem, input logic [12:0] den);
    logic [13:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, den}) return {1'b1, 13'(t - {1'b0, den})};
    return {1'b0, t[12:0]};
  endfunction

  always_comb begin
    logic [13:0] s1, s2;
    for (int l = 0; l < 4; l++) begin
      s1 = div_step(div_rem[l], div_den[l]);
      s2 = div_step(s1[12:0], div_den[l]);
      rem_next[l] = s2[12:0];
      qbits[l]    = {s1[13], s2[13]};
    end
  end

  // job register, filled from the divider
  logic        job_valid;
  logic [31:0] job_a0, job_a1, job_b0, job_b1;
  logic [1:0]  job_kind;
  logic        job_cap;
  logic [4:0]  idx;
  logic        adv, emit, last_v, job_load;
  logic [4:0]  last_idx;

  assign s_tready = !div_busy && !div_done;

  always_comb begin
    if (job_kind == sbvg_pkg::KIND_BAD)          last_idx = 5'd0;
    else if (job_kind == sbvg_pkg::KIND_EQUATOR) last_idx = 5'd5;
    else if (job_cap)                            last_idx = 5'd17;
    else                                         last_idx = 5'd11;
  end

  assign emit     = job_valid && adv;
  assign last_v   = (idx == last_idx);
  assign job_load = div_done && (!job_valid || (emit && last_v));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
      end else if (div_busy) begin
        div_cnt <= div_cnt + 4'd1;
        if (div_cnt == 4'd15) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end else if (job_load) begin
        div_done <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      div_rem[0] <= {3'd0, in_slice};
      div_rem[1] <= {2'd0, a1_init};
      div_rem[2] <= (in_band == 9'd0) ? 13'd1 : {2'd0, u0};
      div_rem[3] <= {2'd0, u1};
      div_den[0] <= {2'd0, lim_l};
      div_den[1] <= {2'd0, lim_l};
      div_den[2] <= {lim_s, 2'b00};
      div_den[3] <= {lim_s, 2'b00};
      div_kind   <= kind_in;
      div_cap    <= cap;
    end else if (div_busy) begin
      for (int l = 0; l < 4; l++) begin
        div_rem[l] <= rem_next[l];
        div_quo[l] <= {div_quo[l][29:0], qbits[l]};
      end
    end
  end

  // vertex sequencer
  sbvg_pkg::vsel_t sel;
  logic [31:0] seq_aph, seq_bph;
  logic [1:0]  seq_vk;

  always_comb begin
    sel     = sbvg_pkg::vert_sel(idx, job_kind == sbvg_pkg::KIND_EQUATOR);
    seq_aph = sel.alpha_hi ? job_a1 : job_a0;
    case (sel.beta_sel)
      sbvg_pkg::B_U0_POS: seq_bph = job_b0;
      sbvg_pkg::B_U0_NEG: seq_bph = 32'd0 - job_b0;
      sbvg_pkg::B_U1_POS: seq_bph = job_b1;
      default:            seq_bph = 32'd0 - job_b1;
    endcase
    seq_vk = (job_kind == sbvg_pkg::KIND_BAD) ? sbvg_pkg::VK_ZERO : sel.vkind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) idx <= last_v ? 5'd0 : idx + 5'd1;
      if (job_load)          job_valid <= 1'b1;
      else if (emit && last_v) job_valid <= 1'b0;
    end
    if (job_load) begin
      job_a0   <= div_quo[0];
      job_a1   <= div_quo[1];
      job_b0   <= div_quo[2];
      job_b1   <= div_quo[3];
      job_kind <= div_kind;
      job_cap  <= div_cap;
    end
  end

  // cordic pipeline, alpha in lane a and beta in lane b
  logic signed [CW-1:0] ax [0:N];
  logic signed [CW-1:0] ay [0:N];
  logic signed [ZW-1:0] az [0:N];
  logic signed [CW-1:0] bx [0:N];
  logic signed [CW-1:0] by [0:N];
  logic signed [ZW-1:0] bz [0:N];
  logic [1:0]           aq [0:N];
  logic [1:0]           bq [0:N];
  logic [1:0]           vk [0:N];
  logic                 lst [0:N];
  logic                 vld [0:N];
  logic                 bad [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= job_valid;
    if (adv) begin
      ax[0]  <= sbvg_pkg::CORDIC_K;
      ay[0]  <= '0;
      az[0]  <= {3'd0, seq_aph[29:0]};
      aq[0]  <= seq_aph[31:30];
      bx[0]  <= sbvg_pkg::CORDIC_K;
      by[0]  <= '0;
      bz[0]  <= {3'd0, seq_bph[29:0]};
      bq[0]  <= seq_bph[31:30];
      vk[0]  <= seq_vk;
      lst[0] <= last_v;
      bad[0] <= (job_kind == sbvg_pkg::KIND_BAD);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(sbvg_pkg::ATAN_TAB[k]);
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (adv) vld[k+1] <= vld[k];
      if (adv) begin
        if (!az[k][ZW-1]) begin
          ax[k+1] <= ax[k] - (ay[k] >>> k);
          ay[k+1] <= ay[k] + (ax[k] >>> k);
          az[k+1] <= az[k] - ATAN;
        end else begin
          ax[k+1] <= ax[k] + (ay[k] >>> k);
          ay[k+1] <= ay[k] - (ax[k] >>> k);
          az[k+1] <= az[k] + ATAN;
        end
        if (!bz[k][ZW-1]) begin
          bx[k+1] <= bx[k] - (by[k] >>> k);
          by[k+1] <= by[k] + (bx[k] >>> k);
          bz[k+1] <= bz[k] - ATAN;
        end else begin
          bx[k+1] <= bx[k] + (by[k] >>> k);
          by[k+1] <= by[k] - (bx[k] >>> k);
          bz[k+1] <= bz[k] + ATAN;
        end
        aq[k+1]  <= aq[k];
        bq[k+1]  <= bq[k];
        vk[k+1]  <= vk[k];
        lst[k+1] <= lst[k];
        bad[k+1] <= bad[k];
      end
    end
  end

  // quadrant fold
  logic signed [CW-1:0] f_ca, f_sa, f_cb, f_sb;
  logic [1:0]           f_vk;
  logic                 f_lst, f_vld, f_bad;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (adv) f_vld <= vld[N];
    if (adv) begin
      case (aq[N])
        2'd0:    begin f_ca <= ax[N];  f_sa <= ay[N];  end
        2'd1:    begin f_ca <= -ay[N]; f_sa <= ax[N];  end
        2'd2:    begin f_ca <= -ax[N]; f_sa <= -ay[N]; end
        default: begin f_ca <= ay[N];  f_sa <= -ax[N]; end
      endcase
      case (bq[N])
        2'd0:    begin f_cb <= bx[N];  f_sb <= by[N];  end
        2'd1:    begin f_cb <= -by[N]; f_sb <= bx[N];  end
        2'd2:    begin f_cb <= -bx[N]; f_sb <= -by[N]; end
        default: begin f_cb <= by[N];  f_sb <= -bx[N]; end
      endcase
      f_vk  <= vk[N];
      f_lst <= lst[N];
      f_bad <= bad[N];
    end
  end

  // first multiply: cos(beta) times sin/cos(alpha), radius times sin(beta)
  logic signed [16:0] r_s;
  logic signed [67:0] p_x, p_z, r_x, r_z;
  logic signed [50:0] p_y, r_y;

  assign r_s = $signed({1'b0, radius});
  assign p_x = f_cb * f_sa;
  assign p_z = f_cb * f_ca;
  assign p_y = r_s * f_sb;
  assign r_x = (p_x + 68'sd536870912) >>> 30;
  assign r_z = (p_z + 68'sd536870912) >>> 30;
  assign r_y = (p_y + 51'sd536870912) >>> 30;

  logic signed [CW-1:0] m1_x, m1_z;
  logic signed [21:0]   m1_y;
  logic [1:0]           m1_vk;
  logic                 m1_lst, m1_vld, m1_bad;

  always_ff @(posedge clk) begin
    if (rst) m1_vld <= 1'b0;
    else if (adv) m1_vld <= f_vld;
    if (adv) begin
      m1_x   <= r_x[CW-1:0];
      m1_z   <= r_z[CW-1:0];
      m1_y   <= r_y[21:0];
      m1_vk  <= f_vk;
      m1_lst <= f_lst;
      m1_bad <= f_bad;
    end
  end

  // second multiply: radius times the horizontal terms
  logic signed [50:0] q_x, q_z, s_x, s_z;

  assign q_x = r_s * m1_x;
  assign q_z = r_s * m1_z;
  assign s_x = (q_x + 51'sd536870912) >>> 30;
  assign s_z = (q_z + 51'sd536870912) >>> 30;

  logic signed [21:0] m2_x, m2_y, m2_z;
  logic [1:0]         m2_vk;
  logic               m2_lst, m2_vld, m2_bad;

  always_ff @(posedge clk) begin
    if (rst) m2_vld <= 1'b0;
    else if (adv) m2_vld <= m1_vld;
    if (adv) begin
      m2_x   <= s_x[21:0];
      m2_z   <= s_z[21:0];
      m2_y   <= m1_y;
      m2_vk  <= m1_vk;
      m2_lst <= m1_lst;
      m2_bad <= m1_bad;
    end
  end

  // saturation and pole override into the output register
  function automatic logic [16:0] sat17(input logic signed [21:0] v);
    if (v > 22'sd65535)  return 17'h0FFFF;
    if (v < -22'sd65535) return 17'h10001;
    return v[16:0];
  endfunction

  logic [16:0] o_x, o_y, o_z;
  logic        o_lst, o_bad, o_vld;
  logic [16:0] rad17;

  assign rad17 = {1'b0, radius};
  assign adv   = !o_vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (adv) o_vld <= m2_vld;
    if (adv) begin
      case (m2_vk)
        sbvg_pkg::VK_NORMAL: begin
          o_x <= sat17(m2_x);
          o_y <= sat17(m2_y);
          o_z <= sat17(m2_z);
        end
        sbvg_pkg::VK_TOP: begin
          o_x <= '0;
          o_y <= rad17;
          o_z <= '0;
        end
        sbvg_pkg::VK_BOTTOM: begin
          o_x <= '0;
          o_y <= 17'd0 - rad17;
          o_z <= '0;
        end
        default: begin
          o_x <= '0;
          o_y <= '0;
          o_z <= '0;
        end
      endcase
      o_lst <= m2_lst;
      o_bad <= m2_bad;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = {5'd0, o_z, o_y, o_x};
  assign m_tlast  = o_lst;
  assign m_tuser  = o_bad;

endmodule

>>> bench/tb.sv
// testbench for the sphere band vertex generator: random and directed requests checked per vertex
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIV = 1024;
  localparam int STEPS   = 16;
  localparam int COORD_MAX = 65535;
  localparam int WATCHDOG = 20000;
  // register index that maps to no register
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic        last;
    logic        bad;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] radius_reg;
  logic [10:0] slices_reg;
  logic [10:0] stacks_reg;

  vertex_t vertex_queue[$];
  int      failures = 0;
  int      idle_cycles = 0;
  bit      stall_free = 1'b0;

  sphere_band_vertex_generator #(.MAX_DIVISIONS(MAX_DIV), .CORDIC_STEPS(STEPS)) DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tlast, .m_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void rotate(logic [31:0] phase, output longint c, output longint s);
    longint atan_q[24] = '{536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443, 41721, 20860,
      10430, 5215, 2607, 1303, 651, 325, 162, 81};
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(phase[29:0]);
    for (int k = 0; k < STEPS && k < 24; k++) begin
      dx = floor_shift(y, k);
      dy = floor_shift(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[k];
      end else begin
        x += dx; y -= dy; z += atan_q[k];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [16:0] clamp(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < -COORD_MAX) v = -COORD_MAX;
    return v[16:0];
  endfunction

  function automatic vertex_t make_vertex(longint x, longint y, longint z);
    vertex_t v;
    v.x = clamp(x); v.y = clamp(y); v.z = clamp(z);
    v.last = 1'b0; v.bad = 1'b0;
    return v;
  endfunction

  function automatic vertex_t sphere_point(longint a, longint n, longint slices, longint stacks);
    logic [63:0] m, ap, bp;
    longint ca, sa, cb, sb, r;
    logic [31:0] beta;
    r = radius_reg;
    ap = (64'(a) << 32) / 64'(slices);
    m = n < 0 ? -n : n;
    bp = (m << 32) / (4 * 64'(stacks));
    beta = n < 0 ? 32'(0) - bp[31:0] : bp[31:0];
    rotate(ap[31:0], ca, sa);
    rotate(beta, cb, sb);
    return make_vertex(round_mul(r, round_mul(cb, sa)), round_mul(r, sb),
                       round_mul(r, round_mul(cb, ca)));
  endfunction

  // builds the vertex run that one request produces
  task automatic predict_band(logic [9:0] slice, logic [8:0] band);
    longint ls, ss, a0, a1, u0, u1, j;
    vertex_t run[$];
    vertex_t rejected;
    bit odd, ok;
    ls = slices_reg > MAX_DIV ? MAX_DIV : slices_reg;
    ss = stacks_reg > MAX_DIV ? MAX_DIV : stacks_reg;
    odd = ss[0];
    ok = ls != 0 && ss != 0 && slice < ls;
    if (ok) ok = band == 0 ? odd : (band + 1 <= ss / 2);
    a0 = slice; a1 = slice + 1;
    if (!ok) begin
      rejected = make_vertex(0, 0, 0);
      rejected.bad = 1'b1;
      run = {run, rejected};
    end else if (band == 0) begin
      run = {run, sphere_point(a0, -1, ls, ss)};
      run = {run, sphere_point(a1, -1, ls, ss)};
      run = {run, sphere_point(a0, 1, ls, ss)};
      run = {run, sphere_point(a0, 1, ls, ss)};
      run = {run, sphere_point(a1, -1, ls, ss)};
      run = {run, sphere_point(a1, 1, ls, ss)};
    end else begin
      j = band - 1;
      u0 = odd + 2 * j;
      u1 = u0 + 2;
      run = {run, sphere_point(a0, u0, ls, ss)};
      run = {run, sphere_point(a1, u0, ls, ss)};
      run = {run, sphere_point(a0, u1, ls, ss)};
      run = {run, sphere_point(a0, u1, ls, ss)};
      run = {run, sphere_point(a1, u0, ls, ss)};
      run = {run, sphere_point(a1, u1, ls, ss)};
      run = {run, sphere_point(a1, -u0, ls, ss)};
      run = {run, sphere_point(a0, -u0, ls, ss)};
      run = {run, sphere_point(a1, -u1, ls, ss)};
      run = {run, sphere_point(a1, -u1, ls, ss)};
      run = {run, sphere_point(a0, -u0, ls, ss)};
      run = {run, sphere_point(a0, -u1, ls, ss)};
      if (band + 1 == ss / 2) begin
        run = {run, sphere_point(a0, u1, ls, ss)};
        run = {run, sphere_point(a1, u1, ls, ss)};
        run = {run, make_vertex(0, radius_reg, 0)};
        run = {run, make_vertex(0, -longint'(radius_reg), 0)};
        run = {run, sphere_point(a1, -u1, ls, ss)};
        run = {run, sphere_point(a0, -u1, ls, ss)};
      end
    end
    run[run.size() - 1].last = 1'b1;
    vertex_queue = {vertex_queue, run};
  endtask

  // tvalid stays high on return so a request with no wait follows at once
  task automatic send_request(logic [9:0] slice, logic [8:0] band);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, band, slice};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_band(slice, band);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (vertex_queue.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      sbvg_pkg::REG_RADIUS: radius_reg = value;
      sbvg_pkg::REG_SLICES: slices_reg = value[10:0];
      sbvg_pkg::REG_STACKS: stacks_reg = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sphere(logic [15:0] r, logic [10:0] sl, logic [10:0] st);
    drain();
    write_reg(sbvg_pkg::REG_RADIUS, r);
    write_reg(sbvg_pkg::REG_SLICES, {5'd0, sl});
    write_reg(sbvg_pkg::REG_STACKS, {5'd0, st});
  endtask

  task automatic test_reset_defaults();
    send_request(10'd0, 9'd1);
    send_request(10'd15, 9'd7);
    send_request(10'd16, 9'd1);
    send_request(10'd3, 9'd0);
    send_request(10'd3, 9'd8);
  endtask

  task automatic test_odd_extremes();
    set_sphere(16'hFFFF, 11'd1024, 11'd1023);
    send_request(10'd0, 9'd0);
    send_request(10'd1023, 9'd0);
    send_request(10'd1023, 9'd510);
    send_request(10'd512, 9'd511);
    send_request(10'd0, 9'd1);
    set_sphere(16'd0, 11'd2047, 11'd3);
    send_request(10'd1023, 9'd0);
    send_request(10'd5, 9'd1);
    send_request(10'd5, 9'd0);
  endtask

  task automatic test_zero_counts();
    set_sphere(16'd300, 11'd0, 11'd8);
    send_request(10'd0, 9'd1);
    set_sphere(16'd300, 11'd4, 11'd0);
    send_request(10'd0, 9'd0);
    send_request(10'd0, 9'd1);
    set_sphere(16'd500, 11'd1, 11'd1);
    send_request(10'd0, 9'd0);
    send_request(10'd0, 9'd1);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(10'd0, 9'd0);
  endtask

  // mostly valid bands so the loop and pole paths get exercised
  task automatic test_random(int count, logic [15:0] r, logic [10:0] sl, logic [10:0] st);
    int lim_s, lim_b;
    set_sphere(r, sl, st);
    lim_s = sl > MAX_DIV ? MAX_DIV : sl;
    lim_b = (st > MAX_DIV ? MAX_DIV : st) / 2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0 || lim_s == 0) begin
        send_request(10'($urandom), 9'($urandom));
      end else begin
        send_request(10'($urandom_range(0, lim_s - 1)),
                     9'($urandom_range(0, lim_b > 1 ? lim_b - 1 : 0)));
      end
    end
  endtask

  // result side waits a drawn number of cycles before each transfer, and none while stall_free is set
  always begin : sink
    int hold;
    @(negedge clk);
    hold = stall_free ? 0 : $urandom_range(0, 7);
    if (hold != 0) begin
      m_tready <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    m_tready <= 1'b1;
    @(posedge clk);
    while (!(m_tvalid && m_tready)) @(posedge clk);
  end

  always @(posedge clk) begin
    vertex_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_queue.size() == 0) begin
        $error("unexpected vertex transfer %h", m_tdata);
        failures++;
      end else begin
        want = vertex_queue.pop_front();
        if (m_tdata[16:0] !== want.x) begin
          $error("x_coord expected %h got %h", want.x, m_tdata[16:0]); failures++;
        end
        if (m_tdata[33:17] !== want.y) begin
          $error("y_coord expected %h got %h", want.y, m_tdata[33:17]); failures++;
        end
        if (m_tdata[50:34] !== want.z) begin
          $error("z_coord expected %h got %h", want.z, m_tdata[50:34]); failures++;
        end
        if (m_tlast !== want.last) begin
          $error("last_vertex expected %b got %b", want.last, m_tlast); failures++;
        end
        if (m_tuser !== want.bad) begin
          $error("bad_request expected %b got %b", want.bad, m_tuser); failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    radius_reg = sbvg_pkg::RADIUS_RST;
    slices_reg = sbvg_pkg::SLICE_RST;
    stacks_reg = sbvg_pkg::STACK_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_odd_extremes();
    test_zero_counts();
    test_random(60, 16'd256, 11'd16, 11'd16);
    test_random(50, 16'($urandom), 11'd7, 11'd9);
    stall_free = 1'b1;
    test_random(30, 16'hFFFF, 11'd1024, 11'd6);
    stall_free = 1'b0;
    test_random(60, 16'($urandom), 11'($urandom_range(1, 1200)), 11'($urandom_range(1, 40)));
    test_random(60, 16'd1, 11'd3, 11'($urandom_range(1024, 2047)));
    test_random(60, 16'($urandom), 11'($urandom_range(1, 64)), 11'($urandom_range(2, 12)));
    drain();
    if (failures == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
